[rtl/wfpa_pkg.sv]
// shared types and constants of the worst-fit partition allocator
`timescale 1ns / 1ps
`default_nettype none

package wfpa_pkg;

  // partition store geometry
  localparam int MAX_PARTITIONS = 16;
  localparam int SIZE_BITS      = 16;

  // fixed field widths of the stream beats and the config register
  localparam int CMD_W  = 1;
  localparam int LIDX_W = 4;
  localparam int AMT_W  = 16;
  localparam int STAT_W = 2;
  localparam int PART_W = 4;
  localparam int HOLE_W = 16;
  localparam int PIU_W  = 5;

  localparam int IN_DATA_W  = ((LIDX_W + AMT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((PART_W + HOLE_W + 7) / 8) * 8;

  // derived widths
  localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
  localparam int LIM_W = (CNT_W > PIU_W) ? CNT_W : PIU_W;
  localparam int CMP_W = (LIM_W > LIDX_W) ? LIM_W : LIDX_W;

  localparam logic [PIU_W-1:0] PIU_RESET = PIU_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_LOADED    = 2'd0,
    STAT_ALLOCATED = 2'd1,
    STAT_NO_FIT    = 2'd2
  } status_e;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     addr;
    logic [SIZE_BITS-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    status_e           status;
    logic [PART_W-1:0] partition;
    logic [HOLE_W-1:0] hole;
  } result_t;

endpackage

`default_nettype wire

[rtl/wfpa_space_ram.sv]
// partition free-space memory with per-entry valid bits cleared at reset
`timescale 1ns / 1ps
`default_nettype none

module wfpa_space_ram
  import wfpa_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ram_rd_t              rd_i,
  input  wire ram_wr_t              wr_i,
  output logic [SIZE_BITS-1:0]      rd_data_o
);

  logic [SIZE_BITS-1:0]      mem [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] valid_q;
  logic [SIZE_BITS-1:0]      mem_rd_q;
  logic                      vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      mem_rd_q <= mem[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        vld_rd_q <= valid_q[rd_i.addr];
      end
    end
  end

  // an entry never written reads as zero
  assign rd_data_o = vld_rd_q ? mem_rd_q : '0;

endmodule

`default_nettype wire

[rtl/wfpa_scan.sv]
// command sequencer: load write, worst-fit scan over the store and write-back
`timescale 1ns / 1ps
`default_nettype none

module wfpa_scan
  import wfpa_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [PIU_W-1:0]     piu_i,
  input  wire logic                 cmd_valid_i,
  output logic                      cmd_ready_o,
  input  wire cmd_e                 cmd_i,
  input  wire logic [LIDX_W-1:0]    load_index_i,
  input  wire logic [AMT_W-1:0]     amount_i,
  output logic                      res_valid_o,
  input  wire logic                 res_ready_i,
  output result_t                   res_o,
  output ram_rd_t                   ram_rd_o,
  output ram_wr_t                   ram_wr_o,
  input  wire logic [SIZE_BITS-1:0] ram_rd_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic [SIZE_BITS-1:0] amount_q, amount_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic [SIZE_BITS-1:0] best_val_q, best_val_d;
  logic                 wb_q, wb_d;
  logic [SIZE_BITS-1:0] wb_val_q, wb_val_d;
  result_t              res_q, res_d;

  logic [LIM_W-1:0]     limit_wide;
  logic [CNT_W-1:0]     limit;
  logic                 issue;
  logic                 accept;
  logic                 load_in_range;
  logic [SIZE_BITS-1:0] hole;

  // requests never search past the store depth
  assign limit_wide = (LIM_W'(piu_i) > LIM_W'(MAX_PARTITIONS)) ?
                      LIM_W'(MAX_PARTITIONS) : LIM_W'(piu_i);
  assign limit      = CNT_W'(limit_wide);

  assign cmd_ready_o   = (state_q == ST_IDLE);
  assign accept        = cmd_valid_i && cmd_ready_o;
  assign load_in_range = CMP_W'(load_index_i) < CMP_W'(MAX_PARTITIONS);
  assign issue         = (state_q == ST_SCAN) && (cnt_q < limit);
  assign hole          = best_val_q - amount_q;

  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  always_comb begin
    ram_rd_o.en   = issue;
    ram_rd_o.addr = cnt_q[IDX_W-1:0];
  end

  // one write port: a load from idle, or the write-back as the result leaves
  always_comb begin
    ram_wr_o.en   = 1'b0;
    ram_wr_o.addr = best_idx_q;
    ram_wr_o.data = wb_val_q;
    if (accept && (cmd_i == CMD_LOAD) && load_in_range) begin
      ram_wr_o.en   = 1'b1;
      ram_wr_o.addr = IDX_W'(load_index_i);
      ram_wr_o.data = SIZE_BITS'(amount_i);
    end else if ((state_q == ST_DONE) && res_ready_i && wb_q) begin
      ram_wr_o.en = 1'b1;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rd_pend_d  = 1'b0;
    rd_idx_d   = rd_idx_q;
    amount_d   = amount_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    wb_d       = wb_q;
    wb_val_d   = wb_val_q;
    res_d      = res_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_LOAD) begin
            res_d.status    = STAT_LOADED;
            res_d.partition = '0;
            res_d.hole      = '0;
            wb_d            = 1'b0;
            state_d         = ST_DONE;
          end else begin
            amount_d = SIZE_BITS'(amount_i);
            cnt_d    = '0;
            found_d  = 1'b0;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cnt_d     = cnt_q + 1'b1;
          rd_pend_d = 1'b1;
          rd_idx_d  = cnt_q[IDX_W-1:0];
        end
        // strict compare keeps the lowest index on ties
        if (rd_pend_q && (ram_rd_data_i >= amount_q) &&
            (!found_q || (best_val_q < ram_rd_data_i))) begin
          found_d    = 1'b1;
          best_idx_d = rd_idx_q;
          best_val_d = ram_rd_data_i;
        end
        if (!issue && !rd_pend_q) begin
          wb_d     = found_q;
          wb_val_d = hole;
          if (found_q) begin
            res_d.status    = STAT_ALLOCATED;
            res_d.partition = PART_W'(best_idx_q);
            res_d.hole      = HOLE_W'(hole);
          end else begin
            res_d.status    = STAT_NO_FIT;
            res_d.partition = '0;
            res_d.hole      = '0;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          wb_d    = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_pend_q <= 1'b0;
      wb_q      <= 1'b0;
      found_q   <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_pend_d;
      wb_q      <= wb_d;
      found_q   <= found_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    amount_q   <= amount_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
    wb_val_q   <= wb_val_d;
    res_q      <= res_d;
  end

`ifndef SYNTHESIS
  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_SCAN))
    else $error("read data pending outside of scan");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_wr_o.en |-> (state_q != ST_SCAN))
    else $error("store written while a scan is running");

  a_wb_only_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && wb_q) |-> (res_q.status == STAT_ALLOCATED))
    else $error("write-back pending without an allocation result");

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= limit))
    else $error("scan counter ran past the partitions in use");
`endif

endmodule

`default_nettype wire

[rtl/worst_fit_partition_allocator_core.sv]
// top level of the worst-fit partition allocator: stream ports, config register, result register
// a load beat writes the store when it is accepted; a request reads min(partitions_in_use, 16)
//   store entries in order, one store read per cycle, and its result passes through the result register
// one beat at a time: a new beat is taken once the result has moved into the result register
// reset: async active low; partitions_in_use goes to 16, the store reads as all zero at once
`timescale 1ns / 1ps
`default_nettype none

module worst_fit_partition_allocator_core
  import wfpa_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config: partitions_in_use
  input  wire logic                  cfg_we_i,
  input  wire logic [PIU_W-1:0]      cfg_wdata_i,
  // input beats
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // load_index [3:0], amount [19:4]
  input  wire logic [CMD_W-1:0]      s_axis_tuser,  // command [0]
  // result beats
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // chosen_partition [3:0], hole_left [19:4]
  output logic [STAT_W-1:0]          m_axis_tuser   // status [1:0]
);

  logic [PIU_W-1:0]     piu_q;
  logic                 out_valid_q;
  result_t              out_q;

  logic                 res_valid;
  logic                 res_ready;
  result_t              res;
  ram_rd_t              ram_rd;
  ram_wr_t              ram_wr;
  logic [SIZE_BITS-1:0] ram_rd_data;

  // partitions_in_use; the user should rewrite it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piu_q <= PIU_RESET;
    end else if (cfg_we_i) begin
      piu_q <= cfg_wdata_i;
    end
  end

  wfpa_space_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (ram_rd),
    .wr_i      (ram_wr),
    .rd_data_o (ram_rd_data)
  );

  wfpa_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .piu_i         (piu_q),
    .cmd_valid_i   (s_axis_tvalid),
    .cmd_ready_o   (s_axis_tready),
    .cmd_i         (cmd_e'(s_axis_tuser)),
    .load_index_i  (s_axis_tdata[LIDX_W-1:0]),
    .amount_i      (s_axis_tdata[LIDX_W+AMT_W-1:LIDX_W]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .ram_rd_o      (ram_rd),
    .ram_wr_o      (ram_wr),
    .ram_rd_data_i (ram_rd_data)
  );

  // result register decouples the sequencer from downstream back-pressure
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = OUT_DATA_W'({out_q.hole, out_q.partition});

endmodule

`default_nettype wire
